// ===== src/gcb_pkg.sv =====
// Shared types, codes and arithmetic helpers for the glyph coverage blend cache.
package gcb_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam logic [1:0] REQ_BLEND = 2'd0;
  localparam logic [1:0] REQ_END   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_TEXT_COLOR     = 2'd0;
  localparam logic [1:0] CFG_SURFACE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_SURFACE_HEIGHT = 2'd2;

  localparam logic [31:0] TEXT_COLOR_RST = 32'hff00_0000;
  localparam logic [9:0]  DIM_RST        = 10'd512;
  localparam logic [7:0]  FULL_BYTE      = 8'hff;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_SWEEP,
    S_ADDR,
    S_READ,
    S_ALPHA,
    S_WRITE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [31:0] dst;
    logic [31:0] color;
    logic [7:0]  alpha;
    logic        full;
  } mix_in_t;

  // floor(v / 255), exact for v below 65280
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'(v[15:8]) + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== src/gcb_mix.sv =====
// Per-pixel blend of the text colour into a stored ARGB word.
module gcb_mix (
  input  gcb_pkg::mix_in_t mi,
  output logic [31:0]      pixel
);

  logic [23:0] mixed;
  logic [7:0]  da;

  for (genvar i = 0; i < 3; i++) begin : g_ch
    logic [15:0] prod;
    assign prod = 16'(mi.dst[8*i +: 8]) * 16'(gcb_pkg::FULL_BYTE - mi.alpha)
                + 16'(mi.color[8*i +: 8]) * 16'(mi.alpha);
    assign mixed[8*i +: 8] = gcb_pkg::div255(prod);
  end

  assign da = (mi.alpha > mi.dst[31:24]) ? mi.alpha : mi.dst[31:24];

  always_comb begin
    if (mi.full) begin
      pixel = mi.color;
    end else if (mi.dst == 32'd0) begin
      pixel = {mi.alpha, mi.color[23:0]};
    end else begin
      pixel = {da, mixed};
    end
  end

endmodule

// ===== src/glyph_coverage_blend_cache.sv =====
// Top level: request sequencer, surface and span memories, valid rectangle.
// Usage:
//   s_axis carries requests: tuser is the request kind (blend, end, read),
//   tdata packs pos_x, pos_y and coverage. m_axis returns one result for each
//   end or read request: pixel, row dirty span and the valid rectangle.
//   cfg writes text_color, surface_width and surface_height; the user must
//   write them only while idle, which the block does not enforce; it is always ready.
// Sequencing, one request at a time through a read-modify-write of the surface
// memory (registered read):
//   end frame: RESULT; read: ADDR, READ, RESULT; clipped or zero blend: ADDR;
//   inking blend: ADDR, READ, ALPHA, WRITE.
//   The blend that opens a frame first passes OPEN and a SWEEP that clears the
//   w*h surface words and, when the span rows must be reset (height differs
//   from the last cleared one), all MAX_HEIGHT span rows.
// Reset: no frame open, rectangle 512/512/0/0, spans and surface read as
//   cleared until first written; no clearing pass runs after reset.
// Stall: a finished result sits in the output register while the next
//   request is taken; a second result waits until the first is transferred.
module glyph_coverage_blend_cache #(
  parameter int MAX_WIDTH  = gcb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = gcb_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pos_x[11:0], pos_y[23:12], coverage[31:24]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pixel_value[31:0], span_first[41:32], span_last[51:42], rect_left[61:52],
  // rect_top[71:62], rect_right[80:72], rect_bottom[89:81], zero fill above
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT);

  gcb_pkg::state_t state, state_next;

  logic [31:0] color;
  logic [9:0]  sw, sh;

  logic [1:0]  req_r;
  logic [11:0] px_r, py_r;
  logic [7:0]  cov_r;

  logic [9:0]  cur_w, cur_h, span_h;
  logic        frame_open, ever_open, spans_init, clr_spans;
  logic [19:0] total;
  logic [20:0] cnt;
  logic [AW-1:0] idx;
  logic        x_in, y_in;
  logic [7:0]  a_r;
  logic        full_r;
  logic [31:0] dst_r;
  logic [9:0]  vl, vt, vr, vb;

  logic [31:0] surf_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [31:0] surf_rdata, surf_wdata;
  logic [AW-1:0] surf_waddr;
  logic        surf_we;
  logic [19:0] span_mem [MAX_HEIGHT];
  logic [19:0] span_rdata, span_wdata;
  logic [HW-1:0] span_waddr;
  logic        span_we;

  logic        in_fire, out_free;
  logic [9:0]  w_new, h_new;
  logic        x_ok, y_ok;
  logic [19:0] idx_full;
  logic        sweep_surf, sweep_span, sweep_done;
  logic [9:0]  lo, hi, lo_n, hi_n, x10, y10;
  logic [7:0]  a_new;
  logic [31:0] mix_pixel;
  gcb_pkg::mix_in_t mi;

  assign s_axis_tready = (state == gcb_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign w_new = (32'(sw) > 32'(MAX_WIDTH))  ? 10'(MAX_WIDTH)  : sw;
  assign h_new = (32'(sh) > 32'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : sh;

  assign x10 = px_r[9:0];
  assign y10 = py_r[9:0];
  assign y_ok = !py_r[11] && (py_r[10:0] < {1'b0, cur_h});
  assign x_ok = !px_r[11] && (px_r[10:0] < {1'b0, cur_w});
  assign idx_full = 20'(y10) * 20'(cur_w) + 20'(x10);

  assign sweep_surf = cnt < {1'b0, total};
  assign sweep_span = clr_spans && (cnt < 21'(MAX_HEIGHT));
  assign sweep_done = !sweep_surf && !sweep_span;

  // dirty span of the row; a half-marked span widens to the whole row
  assign lo = spans_init ? span_rdata[9:0]   : '1;
  assign hi = spans_init ? span_rdata[19:10] : '1;
  always_comb begin
    if (!lo[9] && hi[9]) begin
      lo_n = 10'd0;
      hi_n = cur_w - 10'd1;
    end else begin
      lo_n = (lo[9] || lo > x10) ? x10 : lo;
      hi_n = (hi[9] || hi < x10) ? x10 : hi;
    end
  end

  assign a_new = gcb_pkg::div255(16'(cov_r) * 16'(color[31:24]));

  assign mi.dst   = dst_r;
  assign mi.color = color;
  assign mi.alpha = a_r;
  assign mi.full  = full_r;

  gcb_mix u_mix (
    .mi    (mi),
    .pixel (mix_pixel)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gcb_pkg::S_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            gcb_pkg::REQ_BLEND: state_next = frame_open ? gcb_pkg::S_ADDR : gcb_pkg::S_OPEN;
            gcb_pkg::REQ_END:   state_next = gcb_pkg::S_RESULT;
            gcb_pkg::REQ_READ:  state_next = gcb_pkg::S_ADDR;
            default:            state_next = gcb_pkg::S_IDLE;
          endcase
        end
      end
      gcb_pkg::S_OPEN:  state_next = gcb_pkg::S_SWEEP;
      gcb_pkg::S_SWEEP: if (sweep_done) state_next = gcb_pkg::S_ADDR;
      gcb_pkg::S_ADDR: begin
        if (req_r == gcb_pkg::REQ_BLEND && !(y_ok && x_ok && cov_r != 8'd0)) begin
          state_next = gcb_pkg::S_IDLE;
        end else begin
          state_next = gcb_pkg::S_READ;
        end
      end
      gcb_pkg::S_READ:
        state_next = (req_r == gcb_pkg::REQ_BLEND) ? gcb_pkg::S_ALPHA : gcb_pkg::S_RESULT;
      gcb_pkg::S_ALPHA:  state_next = gcb_pkg::S_WRITE;
      gcb_pkg::S_WRITE:  state_next = gcb_pkg::S_IDLE;
      gcb_pkg::S_RESULT: if (out_free) state_next = gcb_pkg::S_IDLE;
      default:           state_next = gcb_pkg::S_IDLE;
    endcase
  end

  // memory port controls
  always_comb begin
    surf_we    = 1'b0;
    surf_waddr = idx;
    surf_wdata = mix_pixel;
    span_we    = 1'b0;
    span_waddr = HW'(y10);
    span_wdata = {hi_n, lo_n};
    case (state)
      gcb_pkg::S_SWEEP: begin
        surf_we    = sweep_surf;
        surf_waddr = AW'(cnt);
        surf_wdata = 32'd0;
        span_we    = sweep_span;
        span_waddr = HW'(cnt);
        span_wdata = '1;
      end
      gcb_pkg::S_ALPHA: span_we = 1'b1;
      gcb_pkg::S_WRITE: surf_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (surf_we) surf_mem[surf_waddr] <= surf_wdata;
    surf_rdata <= surf_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (span_we) span_mem[span_waddr] <= span_wdata;
    span_rdata <= span_mem[HW'(y10)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= gcb_pkg::TEXT_COLOR_RST;
      sw    <= gcb_pkg::DIM_RST;
      sh    <= gcb_pkg::DIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcb_pkg::CFG_TEXT_COLOR:     color <= cfg_data;
        gcb_pkg::CFG_SURFACE_WIDTH:  sw    <= cfg_data[9:0];
        gcb_pkg::CFG_SURFACE_HEIGHT: sh    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= gcb_pkg::S_IDLE;
      frame_open    <= 1'b0;
      ever_open     <= 1'b0;
      spans_init    <= 1'b0;
      clr_spans     <= 1'b0;
      span_h        <= 10'd0;
      cur_w         <= (MAX_WIDTH < 512)  ? 10'(MAX_WIDTH)  : gcb_pkg::DIM_RST;
      cur_h         <= (MAX_HEIGHT < 512) ? 10'(MAX_HEIGHT) : gcb_pkg::DIM_RST;
      vl            <= gcb_pkg::DIM_RST;
      vt            <= gcb_pkg::DIM_RST;
      vr            <= 10'd0;
      vb            <= 10'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == gcb_pkg::S_RESULT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        gcb_pkg::S_IDLE: begin
          if (in_fire && s_axis_tuser == gcb_pkg::REQ_END) frame_open <= 1'b0;
        end
        gcb_pkg::S_OPEN: begin
          frame_open <= 1'b1;
          cur_w      <= w_new;
          cur_h      <= h_new;
          vl         <= w_new;
          vt         <= h_new;
          vr         <= 10'd0;
          vb         <= 10'd0;
          clr_spans  <= (h_new != span_h);
          span_h     <= h_new;
        end
        gcb_pkg::S_SWEEP: begin
          if (sweep_done) begin
            ever_open <= 1'b1;
            if (clr_spans) spans_init <= 1'b1;
          end
        end
        gcb_pkg::S_ADDR: begin
          if (req_r == gcb_pkg::REQ_BLEND && y_ok) begin
            if (vt > y10) vt <= y10;
            if (vb < y10) vb <= y10;
          end
        end
        gcb_pkg::S_ALPHA: begin
          if (vl > x10) vl <= x10;
          if (vr < x10) vr <= x10;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= s_axis_tuser;
      px_r  <= s_axis_tdata[11:0];
      py_r  <= s_axis_tdata[23:12];
      cov_r <= s_axis_tdata[31:24];
    end
    case (state)
      gcb_pkg::S_OPEN: begin
        total <= 20'(w_new) * 20'(h_new);
        cnt   <= 21'd0;
      end
      gcb_pkg::S_SWEEP: cnt <= cnt + 21'd1;
      gcb_pkg::S_ADDR: begin
        idx  <= AW'(idx_full);
        x_in <= x_ok;
        y_in <= y_ok;
      end
      gcb_pkg::S_ALPHA: begin
        dst_r  <= surf_rdata;
        a_r    <= a_new;
        full_r <= (cov_r == gcb_pkg::FULL_BYTE) && (color[31:24] == gcb_pkg::FULL_BYTE);
      end
      gcb_pkg::S_RESULT: begin
        if (out_free) begin
          m_axis_tdata[31:0] <= (req_r == gcb_pkg::REQ_READ && ever_open && x_in && y_in)
                                ? surf_rdata : 32'd0;
          m_axis_tdata[51:32] <= (req_r == gcb_pkg::REQ_READ && y_in && spans_init)
                                 ? span_rdata : '1;
          m_axis_tdata[61:52] <= vl;
          m_axis_tdata[71:62] <= vt;
          m_axis_tdata[80:72] <= vr[8:0];
          m_axis_tdata[89:81] <= vb[8:0];
          m_axis_tdata[95:90] <= 6'd0;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_sweep_zero: assert property (@(posedge clk) disable iff (rst)
    (state == gcb_pkg::S_SWEEP && surf_we) |-> (surf_wdata == 32'd0))
    else $error("sweep writes nonzero data");
  a_open_rect: assert property (@(posedge clk) disable iff (rst)
    (state == gcb_pkg::S_OPEN) |=> (frame_open && vr == 10'd0 && vb == 10'd0))
    else $error("frame open did not reset rectangle");
  a_write_in_frame: assert property (@(posedge clk) disable iff (rst)
    (state == gcb_pkg::S_WRITE) |-> (frame_open && ever_open && x_in && y_in))
    else $error("surface write outside an open frame");
`endif

endmodule

// ===== dv/tb_glyph_coverage_blend_cache.sv =====
// Testbench for the glyph coverage blend cache: directed table, random frames, scoreboard.
module tb_glyph_coverage_blend_cache;

  localparam logic [1:0] REQ_NONE = 2'd3;   // undefined kind, block drops it
  localparam int SURF_W = 512;
  localparam int SURF_H = 512;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int NUM_PHASES = 20;
  localparam int ITEMS_PER_PHASE = 90;

  typedef struct packed {
    logic [31:0] pix;
    logic [9:0]  span_first;
    logic [9:0]  span_last;
    logic [9:0]  left;
    logic [9:0]  top;
    logic [8:0]  right;
    logic [8:0]  bottom;
  } blend_result_t;

  typedef struct {
    logic [1:0]    req;
    int            x;
    int            y;
    int            cov;
    bit            typed;
    blend_result_t res;
  } dir_row_t;

  // state straight after reset: nothing drawn, rectangle 512/512/0/0
  localparam blend_result_t RESET_RES = '{pix: 32'd0, span_first: 10'h3ff, span_last: 10'h3ff,
                                         left: 10'd512, top: 10'd512, right: 9'd0, bottom: 9'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  glyph_coverage_blend_cache i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block state
  bit [31:0] surf_words [0:SURF_W*SURF_H-1];
  int        row_lo [0:SURF_H-1];
  int        row_hi [0:SURF_H-1];
  bit [31:0] ink_color;
  int        reg_w, reg_h;
  int        frame_w, frame_h, spans_h;
  int        rect_l, rect_t, rect_r, rect_b;
  bit        in_frame;

  blend_result_t pending_results [$];
  int  errors = 0;
  int  cycles = 0;
  int  n_results = 0;
  int  n_blends = 0;
  int  n_frames = 0;
  bit  hold_req = 1'b0;

  function automatic int lerp_channel(int d, int s, int a);
    return (d * (255 - a) + s * a) / 255;
  endfunction

  function automatic void start_frame();
    int w, h;
    w = (reg_w > SURF_W) ? SURF_W : reg_w;
    h = (reg_h > SURF_H) ? SURF_H : reg_h;
    in_frame = 1'b1;
    n_frames++;
    if (h != spans_h) begin
      for (int i = 0; i < SURF_H; i++) begin
        row_lo[i] = -1;
        row_hi[i] = -1;
      end
      spans_h = h;
    end
    for (int i = 0; i < w * h; i++) surf_words[i] = '0;
    frame_w = w;
    frame_h = h;
    rect_l = w;
    rect_r = 0;
    rect_t = h;
    rect_b = 0;
  endfunction

  function automatic void apply_blend(int x, int y, int g);
    int idx, ca, a, da;
    bit [31:0] dst;
    if (!in_frame) start_frame();
    if (y < 0 || y >= frame_h) return;
    if (rect_t > y) rect_t = y;
    if (rect_b < y) rect_b = y;
    if (x < 0 || x >= frame_w || g == 0) return;
    if (row_lo[y] >= 0 && row_hi[y] < 0) begin
      row_lo[y] = 0;
      row_hi[y] = frame_w - 1;
    end else begin
      if (row_lo[y] < 0 || row_lo[y] > x) row_lo[y] = x;
      if (row_hi[y] < 0 || row_hi[y] < x) row_hi[y] = x;
    end
    if (rect_l > x) rect_l = x;
    if (rect_r < x) rect_r = x;
    idx = y * frame_w + x;
    ca = ink_color[31:24];
    if (g == 255 && ca == 255) begin
      surf_words[idx] = ink_color;
      return;
    end
    a = g * ca / 255;
    dst = surf_words[idx];
    if (dst == 0) begin
      surf_words[idx] = {a[7:0], ink_color[23:0]};
      return;
    end
    da = dst[31:24];
    if (a > da) da = a;
    surf_words[idx][31:24] = da[7:0];
    surf_words[idx][23:16] = 8'(lerp_channel(dst[23:16], ink_color[23:16], a));
    surf_words[idx][15:8]  = 8'(lerp_channel(dst[15:8], ink_color[15:8], a));
    surf_words[idx][7:0]   = 8'(lerp_channel(dst[7:0], ink_color[7:0], a));
  endfunction

  // returns 1 when the request produces a result
  function automatic bit predict_request(logic [1:0] req, int x, int y, int g,
                                         output blend_result_t res);
    res = '0;
    res.span_first = 10'h3ff;
    res.span_last = 10'h3ff;
    if (req == gcb_pkg::REQ_BLEND) begin
      n_blends++;
      apply_blend(x, y, g);
      return 1'b0;
    end
    if (req == REQ_NONE) return 1'b0;
    if (req == gcb_pkg::REQ_END) begin
      in_frame = 1'b0;
    end else if (y >= 0 && y < frame_h) begin
      res.span_first = 10'(row_lo[y]);
      res.span_last = 10'(row_hi[y]);
      if (x >= 0 && x < frame_w) res.pix = surf_words[y * frame_w + x];
    end
    res.left = 10'(rect_l);
    res.top = 10'(rect_t);
    res.right = 9'(rect_r);
    res.bottom = 9'(rect_b);
    return 1'b1;
  endfunction

  task automatic send_request(logic [1:0] req, int x, int y, int g, bit typed = 1'b0,
                              blend_result_t typed_res = '0);
    blend_result_t res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {g[7:0], y[11:0], x[11:0]};
    do @(posedge clk); while (!s_axis_tready);
    if (predict_request(req, x, y, g, res)) pending_results.push_back(typed ? typed_res : res);
    if ($urandom_range(0, 9) < 2) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gcb_pkg::CFG_TEXT_COLOR:     ink_color = val;
      gcb_pkg::CFG_SURFACE_WIDTH:  reg_w = int'(val[9:0]);
      gcb_pkg::CFG_SURFACE_HEIGHT: reg_h = int'(val[9:0]);
      default: ;
    endcase
  endtask

  // wait until the block has drained, plus a safety margin
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: ready pattern in segments, plus one long hold-off on request
  initial begin
    int seg_len, mode;
    forever begin
      seg_len = $urandom_range(1, 60);
      mode = $urandom_range(0, 2);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        repeat (seg_len) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    blend_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pix = m_axis_tdata[31:0];
      got.span_first = m_axis_tdata[41:32];
      got.span_last = m_axis_tdata[51:42];
      got.left = m_axis_tdata[61:52];
      got.top = m_axis_tdata[71:62];
      got.right = m_axis_tdata[80:72];
      got.bottom = m_axis_tdata[89:81];
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending: %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.pix !== want.pix) begin
          $error("pixel_value exp %h got %h", want.pix, got.pix);
          errors++;
        end
        if (got.span_first !== want.span_first) begin
          $error("span_first exp %h got %h", want.span_first, got.span_first);
          errors++;
        end
        if (got.span_last !== want.span_last) begin
          $error("span_last exp %h got %h", want.span_last, got.span_last);
          errors++;
        end
        if (got.left !== want.left) begin
          $error("rect_left exp %0d got %0d", want.left, got.left);
          errors++;
        end
        if (got.top !== want.top) begin
          $error("rect_top exp %0d got %0d", want.top, got.top);
          errors++;
        end
        if (got.right !== want.right) begin
          $error("rect_right exp %0d got %0d", want.right, got.right);
          errors++;
        end
        if (got.bottom !== want.bottom) begin
          $error("rect_bottom exp %0d got %0d", want.bottom, got.bottom);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  dir_row_t dir_tab [] = '{
    '{gcb_pkg::REQ_READ,   0,     0,     0,   1'b1, RESET_RES},
    '{gcb_pkg::REQ_END,    0,     0,     0,   1'b1, RESET_RES},
    '{gcb_pkg::REQ_READ,   -1,    -2048, 0,   1'b1, RESET_RES},
    '{gcb_pkg::REQ_BLEND,  0,     0,     255, 1'b0, '0},   // opens frame, opaque full ink
    '{gcb_pkg::REQ_BLEND,  511,   511,   128, 1'b0, '0},   // empty pixel takes colour
    '{gcb_pkg::REQ_BLEND,  511,   511,   255, 1'b0, '0},
    '{gcb_pkg::REQ_BLEND,  -1,    5,     200, 1'b0, '0},   // column clipped, row touched
    '{gcb_pkg::REQ_BLEND,  512,   3,     200, 1'b0, '0},
    '{gcb_pkg::REQ_BLEND,  3,     512,   200, 1'b0, '0},
    '{gcb_pkg::REQ_BLEND,  2047,  -2048, 1,   1'b0, '0},
    '{gcb_pkg::REQ_BLEND,  -2048, 2047,  255, 1'b0, '0},
    '{gcb_pkg::REQ_BLEND,  100,   100,   0,   1'b0, '0},   // no ink
    '{gcb_pkg::REQ_BLEND,  100,   100,   1,   1'b0, '0},
    '{gcb_pkg::REQ_BLEND,  100,   100,   77,  1'b0, '0},   // lerp on inked pixel
    '{gcb_pkg::REQ_READ,   511,   511,   0,   1'b0, '0},
    '{gcb_pkg::REQ_READ,   100,   100,   0,   1'b0, '0},
    '{gcb_pkg::REQ_READ,   0,     0,     0,   1'b0, '0},
    '{gcb_pkg::REQ_READ,   512,   0,     0,   1'b0, '0},
    '{gcb_pkg::REQ_READ,   0,     512,   0,   1'b0, '0},
    '{gcb_pkg::REQ_READ,   -2048, 2047,  0,   1'b0, '0},
    '{REQ_NONE,            7,     7,     7,   1'b0, '0},
    '{gcb_pkg::REQ_END,    0,     0,     0,   1'b0, '0},
    '{gcb_pkg::REQ_READ,   100,   100,   0,   1'b0, '0}
  };

  initial begin
    int w, h, ew, eh, r, x, y, g;
    logic [31:0] col;
    ink_color = gcb_pkg::TEXT_COLOR_RST;
    reg_w = int'(gcb_pkg::DIM_RST);
    reg_h = int'(gcb_pkg::DIM_RST);
    for (int i = 0; i < SURF_W * SURF_H; i++) surf_words[i] = '0;
    for (int i = 0; i < SURF_H; i++) begin
      row_lo[i] = -1;
      row_hi[i] = -1;
    end
    frame_w = SURF_W;
    frame_h = SURF_H;
    spans_h = 0;
    rect_l = 512;
    rect_t = 512;
    rect_r = 0;
    rect_b = 0;
    in_frame = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_request(dir_tab[i].req, dir_tab[i].x, dir_tab[i].y, dir_tab[i].cov,
                   dir_tab[i].typed, dir_tab[i].res);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin w = 1; h = 1; end
        1: begin w = 1023; h = 1; end
        2: begin w = 1; h = 1023; end
        3: begin w = 0; h = 5; end
        4: begin w = 512; h = 3; end
        5: begin w = 3; h = 512; end
        6: begin w = 6; h = 0; end
        default: begin w = $urandom_range(1, 24); h = $urandom_range(1, 24); end
      endcase
      case (p % 5)
        0: col = 32'h0000_0000;
        1: col = 32'hffff_ffff;
        2: col = {8'hff, 24'($urandom)};
        default: col = $urandom;
      endcase
      write_reg(gcb_pkg::CFG_TEXT_COLOR, col);
      write_reg(gcb_pkg::CFG_SURFACE_WIDTH, w);
      write_reg(gcb_pkg::CFG_SURFACE_HEIGHT, h);
      cfg_valid <= 1'b0;
      ew = (w > SURF_W) ? SURF_W : w;
      eh = (h > SURF_H) ? SURF_H : h;
      if (p == 9) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        x = $urandom_range(0, ew + 1) - 1;
        y = $urandom_range(0, eh + 1) - 1;
        case ($urandom_range(0, 3))
          0: g = 0;
          1: g = 255;
          default: g = $urandom_range(0, 255);
        endcase
        if (r < 60) send_request(gcb_pkg::REQ_BLEND, x, y, g);
        else if (r < 80) send_request(gcb_pkg::REQ_READ, x, y, 0);
        else if (r < 88) send_request(gcb_pkg::REQ_END, x, y, g);
        else if (r < 96)
          send_request(2'($urandom_range(0, 3)), $urandom_range(0, 4095) - 2048,
                       $urandom_range(0, 4095) - 2048, $urandom_range(0, 255));
        else send_request(REQ_NONE, x, y, g);
      end
      send_request(gcb_pkg::REQ_END, 0, 0, 0);
      drain();
    end

    errors += pending_results.size();
    $display("run: %0d blends over %0d frames, %0d results checked, %0d configurations",
             n_blends, n_frames, n_results, NUM_PHASES + 1);
    $display("covered clipping, zero and full ink, lerp, size clamping and long output stalls");
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
